/* design/rhht_pkg.sv */
// Shared types, constants and helpers for the Robin Hood hash table unit.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none
package rhht_pkg;

   localparam int TableSize = 251;
   localparam int SlotBits  = 8;
   localparam int DistBits  = 9;

   localparam logic [SlotBits-1:0] LastSlot = SlotBits'(TableSize - 1);

   localparam logic [1:0] MODE_SET    = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_UPDATED   = 3'd1;
   localparam logic [2:0] ST_DELETED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FOUND     = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] req_key;
      logic [63:0] key_hash;
      logic [63:0] req_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] out_key;
      logic [63:0] out_value;
      logic [7:0]  entry_count;
   } rsp_type;

   // Classified request handed from the front to the back.
   typedef struct packed {
      logic [1:0]          mode;
      logic [63:0]         key;
      logic [SlotBits-1:0] home;
      logic [63:0]         value;
   } job_type;

   typedef struct packed {
      logic [SlotBits-1:0] probe_dist;
      logic [63:0]         key;
      logic [63:0]         value;
   } entry_type;

   // One byte step of the home-slot reduction: 256 is 5 mod 251, so the
   // running remainder r and the next byte b give 5r + b, below 6 * 251.
   function automatic logic [SlotBits-1:0] mod_step(input logic [SlotBits-1:0] rem,
                                                    input logic [7:0] byte_in);
      logic [10:0] x;
      logic [10:0] r;
      x = 11'({rem, 2'b00}) + 11'(rem) + 11'(byte_in);
      r = x;
      if (x >= 11'(5 * TableSize)) begin
         r = x - 11'(5 * TableSize);
      end else if (x >= 11'(4 * TableSize)) begin
         r = x - 11'(4 * TableSize);
      end else if (x >= 11'(3 * TableSize)) begin
         r = x - 11'(3 * TableSize);
      end else if (x >= 11'(2 * TableSize)) begin
         r = x - 11'(2 * TableSize);
      end else if (x >= 11'(TableSize)) begin
         r = x - 11'(TableSize);
      end
      return r[SlotBits-1:0];
   endfunction

endpackage
`default_nettype wire

/* design/rhht_front.sv */
// Front end: accepts a request word and reduces its hash to a home slot.
// Depends on rhht_pkg.
`default_nettype none
module rhht_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  rhht_pkg::req_type   req_payload,
   output logic                job_valid,
   input  wire                 job_ready,
   output rhht_pkg::job_type   job_data
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_MOD  = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type                       state_ff, state_in;
   logic [63:0]                      hash_ff, hash_in;
   logic [rhht_pkg::SlotBits-1:0]    rem_ff, rem_in;
   logic [2:0]                       step_ff, step_in;
   rhht_pkg::job_type                job_ff, job_in;

   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      job_in   = job_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               hash_in      = req_payload.key_hash;
               rem_in       = '0;
               step_in      = '0;
               job_in.mode  = req_payload.mode;
               job_in.key   = req_payload.req_key;
               job_in.value = req_payload.req_value;
               state_in     = F_MOD;
            end
         end
         F_MOD: begin
            // advance one byte, most significant first
            rem_in  = rhht_pkg::mod_step(rem_ff, hash_ff[63:56]);
            hash_in = {hash_ff[55:0], 8'h00};
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               job_in.home = rhht_pkg::mod_step(rem_ff, hash_ff[63:56]);
               state_in    = F_PUSH;
            end
         end
         F_PUSH: begin
            if (job_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      hash_ff <= hash_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      job_ff  <= job_in;
   end

   assign req_ready = (state_ff == F_IDLE);
   assign job_valid = (state_ff == F_PUSH);
   assign job_data  = job_ff;

endmodule
`default_nettype wire

/* design/rhht_queue.sv */
// Two-entry queue of classified jobs between front and back.
// Depends on rhht_pkg.
`default_nettype none
module rhht_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   output logic                push_ready,
   input  rhht_pkg::job_type   push_data,
   output logic                pop_valid,
   input  wire                 pop_ready,
   output rhht_pkg::job_type   pop_data
);

   rhht_pkg::job_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* design/rhht_back.sv */
// Back end: walks the slot memory for set, delete and get, and holds the
// result register. Depends on rhht_pkg.
`default_nettype none
module rhht_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 job_valid,
   output logic                job_ready,
   input  rhht_pkg::job_type   job_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output rhht_pkg::rsp_type   rsp_payload
);

   localparam int SB = rhht_pkg::SlotBits;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_READ = 4'b0010,
      B_EVAL = 4'b0100,
      B_RESP = 4'b1000
   } bstate_type;

   bstate_type                      state_ff, state_in;
   rhht_pkg::job_type               job_ff, job_in;
   logic [SB-1:0]                   idx_ff, idx_in;
   logic [rhht_pkg::DistBits-1:0]   cd_ff, cd_in;
   logic [63:0]                     ck_ff, ck_in;
   logic [63:0]                     cv_ff, cv_in;
   logic                            shift_ff, shift_in;
   logic [7:0]                      count_ff, count_in;
   rhht_pkg::rsp_type               res_ff, res_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rhht_pkg::rsp_type               rsp_ff, rsp_in;

   rhht_pkg::entry_type             mem [rhht_pkg::TableSize];
   rhht_pkg::entry_type             rd_data_ff;
   logic [rhht_pkg::TableSize-1:0]  valid_ff, valid_in;

   logic                            wr_en;
   logic [SB-1:0]                   wr_addr;
   rhht_pkg::entry_type             wr_data;
   logic                            set_en, clr_en;
   logic [SB-1:0]                   set_addr, clr_addr;

   logic                            slot_valid, last, out_free, key_hit, ok_get;

   assign slot_valid = valid_ff[idx_ff];
   assign last       = (idx_ff == rhht_pkg::LastSlot);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign key_hit    = (rd_data_ff.key == ck_ff);
   assign ok_get     = (idx_ff == job_ff.home) || (rd_data_ff.probe_dist != '0);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      cd_in    = cd_ff;
      ck_in    = ck_ff;
      cv_in    = cv_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = rd_data_ff;
      set_en   = 1'b0;
      set_addr = idx_ff;
      clr_en   = 1'b0;
      clr_addr = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      res_in.out_key   = '0;
      res_in.out_value = '0;
      res_in.entry_count = count_ff;

      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_in   = job_data;
               idx_in   = job_data.home;
               cd_in    = '0;
               ck_in    = job_data.key;
               cv_in    = job_data.value;
               shift_in = 1'b0;
               state_in = B_READ;
            end
         end
         B_READ: begin
            state_in = B_EVAL;
         end
         B_EVAL: begin
            state_in = B_READ;
            idx_in   = idx_ff + SB'(1);
            if (job_ff.mode == rhht_pkg::MODE_SET) begin
               cd_in = cd_ff + rhht_pkg::DistBits'(1);
               if (!slot_valid) begin
                  wr_en         = 1'b1;
                  wr_data.probe_dist = cd_ff[SB-1:0];
                  wr_data.key   = ck_ff;
                  wr_data.value = cv_ff;
                  set_en        = 1'b1;
                  count_in      = count_ff + 8'd1;
                  res_in.status = rhht_pkg::ST_INSERTED;
                  res_in.entry_count = count_ff + 8'd1;
                  state_in      = B_RESP;
               end else if (key_hit) begin
                  wr_en         = 1'b1;
                  wr_data.probe_dist = cd_ff[SB-1:0];
                  wr_data.value = cv_ff;
                  res_in.status = rhht_pkg::ST_UPDATED;
                  state_in      = B_RESP;
               end else begin
                  if (rhht_pkg::DistBits'(rd_data_ff.probe_dist) < cd_ff) begin
                     // swap: leave the carried entry here, carry the resident on
                     wr_en         = 1'b1;
                     wr_data.probe_dist = cd_ff[SB-1:0];
                     wr_data.key   = ck_ff;
                     wr_data.value = cv_ff;
                     cd_in = rhht_pkg::DistBits'(rd_data_ff.probe_dist) +
                             rhht_pkg::DistBits'(1);
                     ck_in = rd_data_ff.key;
                     cv_in = rd_data_ff.value;
                  end
                  if (last) begin
                     res_in.status    = rhht_pkg::ST_FULL;
                     res_in.out_key   = ck_in;
                     res_in.out_value = cv_in;
                     state_in         = B_RESP;
                  end
               end
            end else if (job_ff.mode == rhht_pkg::MODE_DELETE) begin
               if (shift_ff) begin
                  if (!slot_valid || rd_data_ff.probe_dist == '0) begin
                     res_in.status = rhht_pkg::ST_DELETED;
                     state_in      = B_RESP;
                  end else begin
                     // shift the resident back one slot
                     wr_en        = 1'b1;
                     wr_addr      = idx_ff - SB'(1);
                     wr_data.probe_dist = rd_data_ff.probe_dist - SB'(1);
                     set_en       = 1'b1;
                     set_addr     = idx_ff - SB'(1);
                     clr_en       = 1'b1;
                     if (last) begin
                        res_in.status = rhht_pkg::ST_DELETED;
                        state_in      = B_RESP;
                     end
                  end
               end else if (!slot_valid) begin
                  res_in.status = rhht_pkg::ST_NOT_FOUND;
                  state_in      = B_RESP;
               end else if (key_hit) begin
                  clr_en   = 1'b1;
                  shift_in = 1'b1;
                  if (count_ff != 8'd0) begin
                     count_in           = count_ff - 8'd1;
                     res_in.entry_count = count_ff - 8'd1;
                  end
                  if (last) begin
                     res_in.status = rhht_pkg::ST_DELETED;
                     state_in      = B_RESP;
                  end
               end else if (last) begin
                  res_in.status = rhht_pkg::ST_NOT_FOUND;
                  state_in      = B_RESP;
               end
            end else begin
               if (!slot_valid || !ok_get) begin
                  res_in.status = rhht_pkg::ST_NOT_FOUND;
                  state_in      = B_RESP;
               end else if (key_hit) begin
                  res_in.status    = rhht_pkg::ST_FOUND;
                  res_in.out_value = rd_data_ff.value;
                  state_in         = B_RESP;
               end else if (last) begin
                  res_in.status = rhht_pkg::ST_NOT_FOUND;
                  state_in      = B_RESP;
               end
            end
         end
         B_RESP: begin
            res_in = res_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // occupied flags: clear and set may hit two different slots in one cycle
   always_comb begin
      valid_in = valid_ff;
      if (clr_en) begin
         valid_in[clr_addr] = 1'b0;
      end
      if (set_en) begin
         valid_in[set_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      job_ff   <= job_in;
      idx_ff   <= idx_in;
      cd_ff    <= cd_in;
      ck_ff    <= ck_in;
      cv_ff    <= cv_in;
      shift_ff <= shift_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[idx_ff];
   end

   assign job_ready   = (state_ff == B_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

/* design/robin_hood_hash_table_unit.sv */
// Top level of the Robin Hood hash table unit: front, job queue and back.
// Depends on rhht_pkg, rhht_front, rhht_queue and rhht_back.
`default_nettype none
// A 251-slot key/value table with Robin Hood linear probing (no wrap) and
// backward-shift delete. Each request word carries a mode (set, delete, get;
// code 3 acts as get), a 64-bit key, its 64-bit hash and a value; each
// produces exactly one response word with status, displaced key/value on
// full, found value on get, and the occupied count. The front reduces the
// hash to a home slot one byte per cycle, then hands the job on; a
// two-entry queue lets the next request's reduction overlap the current
// walk. The back visits one slot at a time (registered memory read, then
// evaluate/write); delete also shifts following entries back one slot.
// Requests are served one at a time in the back, in order. The table is
// empty right after reset with no clearing pass: per-slot occupied flags
// are cleared at once.
module robin_hood_hash_table_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  rhht_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output rhht_pkg::rsp_type   rsp_payload
);

   logic              fq_valid, fq_ready;
   rhht_pkg::job_type fq_data;
   logic              qb_valid, qb_ready;
   rhht_pkg::job_type qb_data;

   // hash reduction and classification
   rhht_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .job_valid   (fq_valid),
      .job_ready   (fq_ready),
      .job_data    (fq_data)
   );

   // decouple front from back
   rhht_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // table walk and response register
   rhht_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (qb_valid),
      .job_ready   (qb_ready),
      .job_data    (qb_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

/* design/rhht_checker.sv */
// Port-level checks for the Robin Hood hash table unit, bound to the top.
// Depends on rhht_pkg.
`default_nettype none
module rhht_checker (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input rhht_pkg::rsp_type rsp_payload
);

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status <= rhht_pkg::ST_FULL))
      else $error("illegal status code");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.entry_count <= 8'(rhht_pkg::TableSize)))
      else $error("entry count above table size");

   a_key_only_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != rhht_pkg::ST_FULL) |->
         (rsp_payload.out_key == 64'd0))
      else $error("displaced key shown without full status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("response word dropped or changed while stalled");

endmodule

bind robin_hood_hash_table_unit rhht_checker u_rhht_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
